// ----- rtl/segment_capsule_box_overlap_core_defines.svh -----
// Assertion macros shared by the segment/capsule box overlap RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef SEGMENT_CAPSULE_BOX_OVERLAP_CORE_DEFINES_SVH
`define SEGMENT_CAPSULE_BOX_OVERLAP_CORE_DEFINES_SVH

// Same-cycle implication.
`define SCBO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SCBO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/scbo_pkg.sv -----
// Shared types and constants for the segment/capsule box overlap pipeline.
// No dependencies.
`timescale 1ns / 1ps

package scbo_pkg;

  localparam int unsigned QW      = 18;  // quotient bits (Q1.16 plus sign room)
  localparam int unsigned DIV_LAT = 21;  // divider register stages, input to result register
  localparam int unsigned AX_LAT  = 2;   // axis prep register stages
  // input register + axis prep + divider + order stage + output stage
  localparam int unsigned PIPE_LAT = 1 + AX_LAT + DIV_LAT + 2;

  typedef logic signed [31:0]   coord_t;
  typedef logic signed [33:0]   num_t;
  typedef logic signed [QW-1:0] tq_t;

  localparam tq_t TQ_MAX  = 18'sd131071;
  localparam tq_t TQ_MIN  = -18'sd131072;
  localparam tq_t T_ZERO  = 18'sd0;
  localparam tq_t T_ONE   = 18'sd65536;

  typedef struct packed {
    logic dz;   // zero direction on this axis
    logic pok;  // start lies inside the grown slab
  } axis_flags_t;

endpackage

// ----- rtl/scbo_axis.sv -----
// One axis of the front end: grows the slab by the radius, forms direction
// and the two slab numerators. Depends on scbo_pkg.
`timescale 1ns / 1ps

module scbo_axis (
  input  logic                 clk,
  input  logic                 en,
  input  logic [30:0]          radius,
  input  scbo_pkg::coord_t     bmin,
  input  scbo_pkg::coord_t     bmax,
  input  scbo_pkg::coord_t     s,
  input  scbo_pkg::coord_t     e,
  output scbo_pkg::num_t       nlo,
  output scbo_pkg::num_t       nhi,
  output scbo_pkg::num_t       dir,
  output scbo_pkg::axis_flags_t flags
);

  logic signed [32:0] lo_w, hi_w;
  scbo_pkg::coord_t   lo_sat, hi_sat;
  scbo_pkg::coord_t   lo_r, hi_r, s_r;
  scbo_pkg::num_t     d_r;
  scbo_pkg::num_t     nlo_r, nhi_r, d2_r;
  scbo_pkg::axis_flags_t flags_r;

  // grow with saturation to the signed 32-bit range
  always_comb begin
    lo_w = $signed({bmin[31], bmin}) - $signed({2'b00, radius});
    hi_w = $signed({bmax[31], bmax}) + $signed({2'b00, radius});
    lo_sat = (lo_w[32] != lo_w[31]) ? {lo_w[32], {31{~lo_w[32]}}} : lo_w[31:0];
    hi_sat = (hi_w[32] != hi_w[31]) ? {hi_w[32], {31{~hi_w[32]}}} : hi_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r  <= lo_sat;
      hi_r  <= hi_sat;
      s_r   <= s;
      d_r   <= scbo_pkg::num_t'(e) - scbo_pkg::num_t'(s);
      nlo_r <= scbo_pkg::num_t'(lo_r) - scbo_pkg::num_t'(s_r);
      nhi_r <= scbo_pkg::num_t'(hi_r) - scbo_pkg::num_t'(s_r);
      d2_r  <= d_r;
      flags_r.dz  <= (d_r == '0);
      flags_r.pok <= (s_r >= lo_r) && (s_r <= hi_r);
    end
  end

  assign nlo   = nlo_r;
  assign nhi   = nhi_r;
  assign dir   = d2_r;
  assign flags = flags_r;

endmodule

// ----- rtl/scbo_div.sv -----
// Pipelined signed divider: (num * 2^16) / den, truncated toward zero and
// saturated to Q1.16. One quotient bit per stage. Depends on scbo_pkg.
`timescale 1ns / 1ps

module scbo_div (
  input  logic             clk,
  input  logic             en,
  input  scbo_pkg::num_t   num,
  input  scbo_pkg::num_t   den,
  output scbo_pkg::tq_t    quot
);

  localparam int unsigned QW = scbo_pkg::QW;

  // stage A: magnitudes and sign
  logic        neg_a_r;
  logic [33:0] nm_a_r, dm_a_r;

  // bit stages; index 0 holds the initial remainder
  logic [49:0]   rem_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic [33:0]   dm_r  [0:QW];
  logic          neg_r [0:QW];
  logic          ovf_r [0:QW];

  logic [50:0]   cmp   [0:QW-1];
  logic          ge    [0:QW-1];
  logic [49:0]   rem_nxt [0:QW-1];
  logic [QW-1:0] q_nxt   [0:QW-1];

  scbo_pkg::tq_t quot_r, quot_nxt;
  logic [QW-1:0] qf;
  logic          sat;

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      cmp[i]     = {dm_r[i], 17'b0} >> i;
      ge[i]      = {1'b0, rem_r[i]} >= cmp[i];
      rem_nxt[i] = ge[i] ? 50'({1'b0, rem_r[i]} - cmp[i]) : rem_r[i];
      q_nxt[i]   = q_r[i];
      q_nxt[i][QW-1-i] = ge[i];
    end
  end

  // final sign and saturation
  always_comb begin
    qf = q_r[QW];
    if (neg_r[QW]) begin
      sat      = ovf_r[QW] || (qf > QW'(131072));
      quot_nxt = sat ? scbo_pkg::TQ_MIN : scbo_pkg::tq_t'(-$signed({1'b0, qf}));
    end else begin
      sat      = ovf_r[QW] || qf[QW-1];
      quot_nxt = sat ? scbo_pkg::TQ_MAX : scbo_pkg::tq_t'(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r  <= num[33] ^ den[33];
      nm_a_r   <= num[33] ? 34'(-num) : 34'(num);
      dm_a_r   <= den[33] ? 34'(-den) : 34'(den);
      // quotient magnitude reaches 2^18 exactly when |num| >= 4 |den|
      ovf_r[0] <= {2'b00, nm_a_r} >= {dm_a_r, 2'b00};
      rem_r[0] <= {nm_a_r, 16'b0};
      q_r[0]   <= '0;
      dm_r[0]  <= dm_a_r;
      neg_r[0] <= neg_a_r;
      for (int i = 0; i < QW; i++) begin
        rem_r[i+1] <= rem_nxt[i];
        q_r[i+1]   <= q_nxt[i];
        dm_r[i+1]  <= dm_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

// ----- rtl/segment_capsule_box_overlap_core.sv -----
// Top level of the segment/capsule versus box overlap test (slab method).
// Depends on scbo_pkg, scbo_axis, scbo_div and the defines header.
//
//  channel | signals                                 | transfer when
//  --------+-----------------------------------------+-----------------------
//  in      | in_valid, in_ready, in_box_*, in_seg_*  | in_valid & in_ready
//  out     | out_valid, out_ready, out_hit           | out_valid & out_ready
//  cfg     | cfg_we, cfg_wdata (capsule radius)      | cfg_we
//
// One pair per cycle while the output is not stalled, through PIPE_LAT = 26
// register stages: input register, two axis prep stages, 21 divider stages
// (sign, setup, 18 one-bit steps, saturation), order stage and output register.
// Synchronous active-low reset clears the valid bits and the radius.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "segment_capsule_box_overlap_core_defines.svh"

module segment_capsule_box_overlap_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_box_min_x,
  input  logic signed [31:0]  in_box_min_y,
  input  logic signed [31:0]  in_box_min_z,
  input  logic signed [31:0]  in_box_max_x,
  input  logic signed [31:0]  in_box_max_y,
  input  logic signed [31:0]  in_box_max_z,
  input  logic signed [31:0]  in_seg_start_x,
  input  logic signed [31:0]  in_seg_start_y,
  input  logic signed [31:0]  in_seg_start_z,
  input  logic signed [31:0]  in_seg_end_x,
  input  logic signed [31:0]  in_seg_end_y,
  input  logic signed [31:0]  in_seg_end_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hit
);

  localparam int unsigned PL = scbo_pkg::PIPE_LAT;
  localparam int unsigned DL = scbo_pkg::DIV_LAT;

  logic adv;
  logic [30:0] radius_r;
  logic [PL-1:0] vld_r;

  // input register, one entry per axis
  scbo_pkg::coord_t bmin_r [0:2];
  scbo_pkg::coord_t bmax_r [0:2];
  scbo_pkg::coord_t s_r    [0:2];
  scbo_pkg::coord_t e_r    [0:2];

  scbo_pkg::num_t        nlo [0:2];
  scbo_pkg::num_t        nhi [0:2];
  scbo_pkg::num_t        dir [0:2];
  scbo_pkg::axis_flags_t flg [0:2];
  scbo_pkg::tq_t         t1  [0:2];
  scbo_pkg::tq_t         t2  [0:2];

  // axis flags ride alongside the dividers
  scbo_pkg::axis_flags_t flg_r [0:DL-1][0:2];

  // order stage: per-axis entry/exit t, neutral on zero-direction axes
  scbo_pkg::tq_t ta_r [0:2];
  scbo_pkg::tq_t tb_r [0:2];
  scbo_pkg::tq_t ta_nxt [0:2];
  scbo_pkg::tq_t tb_nxt [0:2];
  logic          pok_r, pok_nxt;

  scbo_pkg::tq_t tmin, tmax;
  logic          hit_r, hit_nxt;

  assign adv      = ~vld_r[PL-1] | out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PL-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bmin_r[0] <= in_box_min_x;   bmax_r[0] <= in_box_max_x;
      bmin_r[1] <= in_box_min_y;   bmax_r[1] <= in_box_max_y;
      bmin_r[2] <= in_box_min_z;   bmax_r[2] <= in_box_max_z;
      s_r[0]    <= in_seg_start_x; e_r[0]    <= in_seg_end_x;
      s_r[1]    <= in_seg_start_y; e_r[1]    <= in_seg_end_y;
      s_r[2]    <= in_seg_start_z; e_r[2]    <= in_seg_end_z;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    scbo_axis u_axis (
      .clk    (clk),
      .en     (adv),
      .radius (radius_r),
      .bmin   (bmin_r[a]),
      .bmax   (bmax_r[a]),
      .s      (s_r[a]),
      .e      (e_r[a]),
      .nlo    (nlo[a]),
      .nhi    (nhi[a]),
      .dir    (dir[a]),
      .flags  (flg[a])
    );

    scbo_div u_div_lo (
      .clk  (clk),
      .en   (adv),
      .num  (nlo[a]),
      .den  (dir[a]),
      .quot (t1[a])
    );

    scbo_div u_div_hi (
      .clk  (clk),
      .en   (adv),
      .num  (nhi[a]),
      .den  (dir[a]),
      .quot (t2[a])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        flg_r[0][a] <= flg[a];
        for (int k = 1; k < DL; k++) begin
          flg_r[k][a] <= flg_r[k-1][a];
        end
      end
    end
  end

  // Order stage: swap so entry <= exit. A zero-direction axis only needs the
  // point test, so it contributes the full [0, 1] interval.
  always_comb begin
    pok_nxt = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (flg_r[DL-1][a].dz) begin
        ta_nxt[a] = scbo_pkg::T_ZERO;
        tb_nxt[a] = scbo_pkg::T_ONE;
        pok_nxt   = pok_nxt & flg_r[DL-1][a].pok;
      end else if (t1[a] > t2[a]) begin
        ta_nxt[a] = t2[a];
        tb_nxt[a] = t1[a];
      end else begin
        ta_nxt[a] = t1[a];
        tb_nxt[a] = t2[a];
      end
    end
  end

  // Narrowing is monotonic, so the axis-by-axis early exit equals a single
  // max/min over all axes.
  always_comb begin
    tmin = scbo_pkg::T_ZERO;
    tmax = scbo_pkg::T_ONE;
    for (int a = 0; a < 3; a++) begin
      if (ta_r[a] > tmin) tmin = ta_r[a];
      if (tb_r[a] < tmax) tmax = tb_r[a];
    end
    hit_nxt = pok_r && (tmin <= tmax);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta_r  <= ta_nxt;
      tb_r  <= tb_nxt;
      pok_r <= pok_nxt;
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = vld_r[PL-1];
  assign out_hit   = hit_r;

  // pipeline freezes completely while the output is held
  `SCBO_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_r) && $stable(hit_r), "pipeline moved during stall")
  // ordered interval per axis after the order stage
  `SCBO_ASSERT_NOW(a_order, vld_r[PL-2], (ta_r[0] <= tb_r[0]) && (ta_r[1] <= tb_r[1]) && (ta_r[2] <= tb_r[2]), "entry t above exit t")
  // a hit requires all point tests on zero-direction axes
  `SCBO_ASSERT_NEXT(a_hit_pok, adv && vld_r[PL-2] && !pok_r, !hit_r, "hit despite failed point test")

endmodule
